>>> design/distinct_palindromic_subseq_count_defines.svh
// Assertion macros shared by the checker of the palindrome counter.
`ifndef DISTINCT_PALINDROMIC_SUBSEQ_COUNT_DEFINES_SVH
`define DISTINCT_PALINDROMIC_SUBSEQ_COUNT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palindrome counter check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define DPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palindrome counter check failed");

`endif

>>> design/dps_pkg.sv
// Shared constants, types and state encodings of the palindrome counter.
package dps_pkg;

  localparam int MAX_LEN = 128;
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = POS_W + 1;
  localparam int CNT_W   = 30;
  localparam int SUM_W   = CNT_W + 2;
  localparam int TAB_DEPTH = MAX_LEN * MAX_LEN;
  localparam int ADDR_W  = $clog2(TAB_DEPTH);
  localparam int SYM_W   = 8;
  localparam int SYMS    = 1 << SYM_W;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam logic [CNT_W-1:0] PRIME = CNT_W'(1000000007);

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef struct packed {
    len_t len;
    logic ovf;
  } job_t;

  typedef struct packed {
    logic str_we;
    pos_t str_addr;
    sym_t str_data;
    logic nxt_we;
    pos_t nxt_addr;
    pos_t nxt_data;
    logic prv_we;
    pos_t prv_addr;
    pos_t prv_data;
  } mem_wr_t;

  typedef enum logic [1:0] {FE_IDLE, FE_LOOK, FE_LINK} fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE, BE_FETCH, BE_PAIR, BE_SUM, BE_WRITE, BE_DONE
  } be_state_t;

  function automatic addr_t tab_addr(pos_t i, pos_t j);
    return ADDR_W'(ADDR_W'(i) * ADDR_W'(MAX_LEN) + ADDR_W'(j));
  endfunction

endpackage

>>> design/distinct_palindromic_subseq_count.sv
// Each byte passes through the front end as store, neighbor lookup and link.
// The count then visits n*(n+1)/2 table cells for n bytes, each through the fetch,
// pair, sum and write states; done follows in the cycle after the last cell.
// A new string is taken only after the previous count has been given out.
// Synchronous reset empties the string, the queue and all control state.
module distinct_palindromic_subseq_count (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [7:0]           symbol,
  input  logic                 last_symbol,
  output logic                 busy,
  output logic                 done,
  output logic [29:0]          palindrome_count,
  output logic                 length_overflow
);
  import dps_pkg::*;

  logic    accept;
  logic    fe_busy;
  mem_wr_t wr;
  logic    push;
  job_t    push_job;
  job_t    head;
  logic    q_empty;
  logic    pop;
  logic    be_active;

  assign busy   = fe_busy | ~q_empty | be_active;
  assign accept = start & ~busy;

  dps_front u_front (
    .clk, .rst, .accept, .symbol, .last_symbol,
    .fe_busy, .wr, .push, .job(push_job)
  );

  dps_queue u_queue (
    .clk, .rst, .push, .push_job, .pop, .head, .empty(q_empty)
  );

  dps_back u_back (
    .clk, .rst, .wr, .q_empty, .head, .pop, .active(be_active),
    .done, .count(palindrome_count), .ovf_out(length_overflow)
  );

endmodule

>>> design/dps_front.sv
// Front end: takes string bytes and links equal bytes to their neighbors.
module dps_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dps_pkg::sym_t   symbol,
  input  logic            last_symbol,
  output logic            fe_busy,
  output dps_pkg::mem_wr_t wr,
  output logic            push,
  output dps_pkg::job_t   job
);
  import dps_pkg::*;

  fe_state_t state, state_next;
  len_t      len;
  logic      ovf;
  sym_t      sym;
  logic      last_r;
  logic [SYMS-1:0] seen_v;
  pos_t      seen_mem [SYMS];
  pos_t      seen_q;
  pos_t      pos;
  logic      room;

  assign pos  = len[POS_W-1:0];
  assign room = len < LEN_W'(MAX_LEN);

  always_ff @(posedge clk) begin
    seen_q <= seen_mem[sym];
    if (state == FE_LINK) begin
      seen_mem[sym] <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FE_IDLE;
      len    <= '0;
      ovf    <= 1'b0;
      seen_v <= '0;
    end else begin
      state <= state_next;
      case (state)
        FE_IDLE: begin
          if (accept) begin
            sym    <= symbol;
            last_r <= last_symbol;
            if (!room) begin
              ovf <= ~last_symbol;
              if (last_symbol) begin
                len    <= '0;
                seen_v <= '0;
              end
            end
          end
        end
        FE_LINK: begin
          if (last_r) begin
            len    <= '0;
            ovf    <= 1'b0;
            seen_v <= '0;
          end else begin
            len         <= len + 1'b1;
            seen_v[sym] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    push       = 1'b0;
    job        = '0;
    case (state)
      FE_IDLE: begin
        if (accept) begin
          if (room) begin
            state_next = FE_LOOK;
          end else if (last_symbol) begin
            push    = 1'b1;
            job.len = len;
            job.ovf = 1'b1;
          end
        end
      end
      FE_LOOK: begin
        wr.str_we   = 1'b1;
        wr.str_addr = pos;
        wr.str_data = sym;
        wr.nxt_we   = 1'b1;
        wr.nxt_addr = pos;
        wr.nxt_data = pos;
        state_next  = FE_LINK;
      end
      FE_LINK: begin
        wr.prv_we   = 1'b1;
        wr.prv_addr = pos;
        wr.prv_data = seen_v[sym] ? seen_q : pos;
        wr.nxt_we   = seen_v[sym];
        wr.nxt_addr = seen_q;
        wr.nxt_data = pos;
        push        = last_r;
        job.len     = len + 1'b1;
        job.ovf     = ovf;
        state_next  = FE_IDLE;
      end
      default: begin
        state_next = FE_IDLE;
      end
    endcase
  end

  assign fe_busy = state != FE_IDLE;

endmodule

>>> design/dps_queue.sv
// Short queue of finished strings between the front end and the table fill.
module dps_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dps_pkg::job_t push_job,
  input  logic          pop,
  output dps_pkg::job_t head,
  output logic          empty
);
  import dps_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  assign head  = slots[rptr];
  assign empty = count == '0;

endmodule

>>> design/dps_back.sv
// Back end: fills the interval table diagonal by diagonal and gives the count.
module dps_back (
  input  logic             clk,
  input  logic             rst,
  input  dps_pkg::mem_wr_t wr,
  input  logic             q_empty,
  input  dps_pkg::job_t    head,
  output logic             pop,
  output logic             active,
  output logic             done,
  output dps_pkg::cnt_t    count,
  output logic             ovf_out
);
  import dps_pkg::*;

  be_state_t state, state_next;
  sym_t  str_mem [MAX_LEN];
  pos_t  nxt_mem [MAX_LEN];
  pos_t  prv_mem [MAX_LEN];
  cnt_t  tab_mem [TAB_DEPTH];

  sym_t  str_qa, str_qb;
  pos_t  nxt_q, prv_q;
  cnt_t  tab_q0, tab_q1;
  addr_t rd0, rd1;

  len_t  n;
  logic  ovf;
  pos_t  span, i, j;
  sym_t  si, sj;
  pos_t  lo, hi;
  logic  dz;
  cnt_t  inner, a;
  logic [SUM_W-1:0] s1;
  logic [SUM_W-1:0] sum, sum_red, v;
  cnt_t  res;
  logic  last_col, last_diag;

  always_ff @(posedge clk) begin
    if (wr.str_we) begin
      str_mem[wr.str_addr] <= wr.str_data;
    end
    if (wr.nxt_we) begin
      nxt_mem[wr.nxt_addr] <= wr.nxt_data;
    end
    if (wr.prv_we) begin
      prv_mem[wr.prv_addr] <= wr.prv_data;
    end
    str_qa <= str_mem[i];
    str_qb <= str_mem[j];
    nxt_q  <= nxt_mem[i];
    prv_q  <= prv_mem[j];
  end

  always_comb begin
    if (state == BE_PAIR) begin
      rd0 = tab_addr(i, j - 1'b1);
      rd1 = tab_addr(nxt_q + 1'b1, prv_q - 1'b1);
    end else begin
      rd0 = tab_addr(i + 1'b1, j - 1'b1);
      rd1 = tab_addr(i + 1'b1, j);
    end
  end

  always_ff @(posedge clk) begin
    tab_q0 <= tab_mem[rd0];
    tab_q1 <= tab_mem[rd1];
    if (state == BE_WRITE) begin
      tab_mem[tab_addr(i, j)] <= v[CNT_W-1:0];
    end
  end

  always_comb begin
    if (span == '0) begin
      sum = SUM_W'(1);
    end else if (span == POS_W'(1)) begin
      sum = SUM_W'(2);
    end else if (si != sj) begin
      sum = SUM_W'(a) + SUM_W'(tab_q0) + SUM_W'(PRIME) - SUM_W'(inner);
    end else if (lo > hi) begin
      sum = (SUM_W'(inner) << 1) + SUM_W'(2);
    end else if (lo == hi) begin
      sum = (SUM_W'(inner) << 1) + SUM_W'(1);
    end else begin
      sum = (SUM_W'(inner) << 1) + SUM_W'(PRIME) - (dz ? '0 : SUM_W'(tab_q1));
    end
    sum_red = (sum >= SUM_W'(PRIME)) ? sum - SUM_W'(PRIME) : sum;
    v       = (s1 >= SUM_W'(PRIME)) ? s1 - SUM_W'(PRIME) : s1;
  end

  assign last_col  = (LEN_W'(j) + 1'b1) == n;
  assign last_diag = (LEN_W'(span) + 1'b1) == n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BE_IDLE;
    end else begin
      state <= state_next;
      case (state)
        BE_IDLE: begin
          if (!q_empty) begin
            n    <= head.len;
            ovf  <= head.ovf;
            span <= '0;
            i    <= '0;
            j    <= '0;
            res  <= '0;
          end
        end
        BE_PAIR: begin
          si    <= str_qa;
          sj    <= str_qb;
          lo    <= nxt_q;
          hi    <= prv_q;
          dz    <= LEN_W'(prv_q) <= LEN_W'(nxt_q) + 1'b1;
          inner <= tab_q0;
          a     <= tab_q1;
        end
        BE_SUM: begin
          s1 <= sum_red;
        end
        BE_WRITE: begin
          res <= v[CNT_W-1:0];
          if (last_col) begin
            span <= span + 1'b1;
            i    <= '0;
            j    <= span + 1'b1;
          end else begin
            i <= i + 1'b1;
            j <= j + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    done       = 1'b0;
    case (state)
      BE_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = (head.len == '0) ? BE_DONE : BE_FETCH;
        end
      end
      BE_FETCH: state_next = BE_PAIR;
      BE_PAIR:  state_next = BE_SUM;
      BE_SUM:   state_next = BE_WRITE;
      BE_WRITE: state_next = (last_col && last_diag) ? BE_DONE : BE_FETCH;
      BE_DONE: begin
        done       = 1'b1;
        state_next = BE_IDLE;
      end
      default: state_next = BE_IDLE;
    endcase
  end

  assign active  = state != BE_IDLE;
  assign count   = res;
  assign ovf_out = ovf;

endmodule

>>> design/dps_checker.sv
// Port-level checks of the palindrome counter and their binding.
`include "distinct_palindromic_subseq_count_defines.svh"

module dps_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        last_symbol,
  input logic        busy,
  input logic        done,
  input logic [29:0] palindrome_count
);

  `DPS_ASSERT_NEXT(a_done_single, done, !done)
  `DPS_ASSERT_NOW(a_done_busy, done, busy)
  `DPS_ASSERT_NOW(a_count_range, done, palindrome_count < 30'd1000000007)
  `DPS_ASSERT_NEXT(a_last_busy, start && !busy && last_symbol, busy)

endmodule

bind distinct_palindromic_subseq_count dps_checker u_checker (
  .clk, .rst, .start, .last_symbol, .busy, .done, .palindrome_count
);
